[sv/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Shared widths, codes and controller/datapath handshake types for the
// rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int OPCODE_WIDTH  = 2;
	localparam int NUM_OUT_WIDTH = 33;
	localparam int DEN_OUT_WIDTH = 32;

	localparam int PROD_WIDTH  = 2 * OPERAND_WIDTH;
	localparam int MAG_WIDTH   = PROD_WIDTH + 1;
	localparam int SHIFT_WIDTH = $clog2(MAG_WIDTH + 1);
	localparam int COUNT_WIDTH = $clog2(MAG_WIDTH);
	localparam int EXT_WIDTH   = (MAG_WIDTH > NUM_OUT_WIDTH) ? MAG_WIDTH : NUM_OUT_WIDTH;

	typedef enum logic [OPCODE_WIDTH-1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		MSEL_P1  = 2'd0,
		MSEL_P2  = 2'd1,
		MSEL_DEN = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     sum;
		logic     gcd_init;
		logic     gcd_step;
		logic     div_step;
		logic     out_load;
	} rau_cmd_t;

	typedef struct packed {
		logic gcd_fin;
	} rau_stat_t;

endpackage

[sv/rau_in_if.sv]
// ----------------------------------------------------------------------------
// rau_in_if
// Operand channel: an opcode and two signed fractions per word.
// ----------------------------------------------------------------------------
interface rau_in_if import rau_pkg::*; ();

	logic                            valid;
	logic                            ready;
	logic [OPCODE_WIDTH-1:0]         opcode;
	logic signed [OPERAND_WIDTH-1:0] num_a;
	logic signed [OPERAND_WIDTH-1:0] den_a;
	logic signed [OPERAND_WIDTH-1:0] num_b;
	logic signed [OPERAND_WIDTH-1:0] den_b;

	modport source (output valid, opcode, num_a, den_a, num_b, den_b, input ready);
	modport sink (input valid, opcode, num_a, den_a, num_b, den_b, output ready);

endinterface

[sv/rau_out_if.sv]
// ----------------------------------------------------------------------------
// rau_out_if
// Result channel: one reduced fraction per word.
// ----------------------------------------------------------------------------
interface rau_out_if import rau_pkg::*; ();

	logic                            valid;
	logic                            ready;
	logic signed [NUM_OUT_WIDTH-1:0] num_out;
	logic signed [DEN_OUT_WIDTH-1:0] den_out;

	modport source (output valid, num_out, den_out, input ready);
	modport sink (input valid, num_out, den_out, output ready);

endinterface

[sv/rau_datapath.sv]
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, shared multiplier, sign-magnitude adder, binary GCD
// unit and a two-lane restoring divider, driven by the controller.
// ----------------------------------------------------------------------------
module rau_datapath import rau_pkg::*; (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rau_cmd_t                        cmd,
	output rau_stat_t                       stat,
	input  logic [OPCODE_WIDTH-1:0]         opcode,
	input  logic signed [OPERAND_WIDTH-1:0] num_a,
	input  logic signed [OPERAND_WIDTH-1:0] den_a,
	input  logic signed [OPERAND_WIDTH-1:0] num_b,
	input  logic signed [OPERAND_WIDTH-1:0] den_b,
	output logic signed [NUM_OUT_WIDTH-1:0] num_out,
	output logic signed [DEN_OUT_WIDTH-1:0] den_out
);

	function automatic logic [OPERAND_WIDTH-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
		logic [OPERAND_WIDTH-1:0] u;
		u = v;
		return v[OPERAND_WIDTH-1] ? (~u + 1'b1) : u;
	endfunction

	opcode_t                  op_q;
	logic                     na_neg_q, da_neg_q, nb_neg_q, db_neg_q;
	logic [OPERAND_WIDTH-1:0] na_mag_q, da_mag_q, nb_mag_q, db_mag_q;

	logic [OPERAND_WIDTH-1:0] x_mag, y_mag;
	logic                     x_neg, y_neg;
	logic [PROD_WIDTH-1:0]    prod;

	logic [PROD_WIDTH-1:0]    p1_mag_q, p2_mag_q, pd_mag_q;
	logic                     p1_neg_q, p2_neg_q, pd_neg_q;

	logic                     p2_neg_eff;
	logic [MAG_WIDTH-1:0]     sum_a, sum_b, sum_ab;
	logic [MAG_WIDTH:0]       diff_ab;
	logic [MAG_WIDTH-1:0]     diff_ba;
	logic [MAG_WIDTH-1:0]     sum_mag;
	logic                     sum_neg;

	logic [MAG_WIDTH-1:0]     nmag_q, dmag_q;
	logic                     nneg_q, dneg_q;

	logic [MAG_WIDTH-1:0]     ga_q, gb_q, g_q, g_next;
	logic [SHIFT_WIDTH-1:0]   k_q;
	logic [MAG_WIDTH:0]       g_diff;

	logic [MAG_WIDTH-1:0]     rem_n_q, rem_d_q, quo_n_q, quo_d_q;
	logic [MAG_WIDTH:0]       shn, shd, trial_n, trial_d, g_ext;

	logic [EXT_WIDTH-1:0]     n_ext, d_ext, n_sgn, d_sgn;
	logic signed [NUM_OUT_WIDTH-1:0] num_out_q;
	logic signed [DEN_OUT_WIDTH-1:0] den_out_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= opcode_t'(opcode);
			na_neg_q <= num_a[OPERAND_WIDTH-1];
			da_neg_q <= den_a[OPERAND_WIDTH-1];
			nb_neg_q <= num_b[OPERAND_WIDTH-1];
			db_neg_q <= den_b[OPERAND_WIDTH-1];
			na_mag_q <= mag_of(num_a);
			da_mag_q <= mag_of(den_a);
			nb_mag_q <= mag_of(num_b);
			db_mag_q <= mag_of(den_b);
		end
	end

	always_comb begin
		x_mag = na_mag_q;
		x_neg = na_neg_q;
		y_mag = db_mag_q;
		y_neg = db_neg_q;
		case (cmd.mul_sel)
			MSEL_P1: begin
				case (op_q)
					OP_ADD: begin
						x_mag = nb_mag_q; x_neg = nb_neg_q;
						y_mag = da_mag_q; y_neg = da_neg_q;
					end
					OP_MUL: begin
						y_mag = nb_mag_q; y_neg = nb_neg_q;
					end
					default: begin
					end
				endcase
			end
			MSEL_P2: begin
				case (op_q)
					OP_ADD: begin
					end
					OP_SUB: begin
						x_mag = nb_mag_q; x_neg = nb_neg_q;
						y_mag = da_mag_q; y_neg = da_neg_q;
					end
					default: begin
						x_mag = '0;
					end
				endcase
			end
			MSEL_DEN: begin
				x_mag = da_mag_q; x_neg = da_neg_q;
				if (op_q == OP_DIV) begin
					y_mag = nb_mag_q; y_neg = nb_neg_q;
				end
			end
			default: begin
			end
		endcase
		prod = PROD_WIDTH'(x_mag) * PROD_WIDTH'(y_mag);
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				MSEL_P1: begin
					p1_mag_q <= prod;
					p1_neg_q <= x_neg ^ y_neg;
				end
				MSEL_P2: begin
					p2_mag_q <= prod;
					p2_neg_q <= x_neg ^ y_neg;
				end
				default: begin
					pd_mag_q <= prod;
					pd_neg_q <= x_neg ^ y_neg;
				end
			endcase
		end
	end

	always_comb begin
		p2_neg_eff = p2_neg_q ^ (op_q == OP_SUB);
		sum_a      = MAG_WIDTH'(p1_mag_q);
		sum_b      = MAG_WIDTH'(p2_mag_q);
		sum_ab     = sum_a + sum_b;
		diff_ab    = {1'b0, sum_a} - {1'b0, sum_b};
		diff_ba    = sum_b - sum_a;
		if (p1_neg_q == p2_neg_eff) begin
			sum_mag = sum_ab;
			sum_neg = p1_neg_q;
		end else if (diff_ab[MAG_WIDTH]) begin
			sum_mag = diff_ba;
			sum_neg = p2_neg_eff;
		end else begin
			sum_mag = diff_ab[MAG_WIDTH-1:0];
			sum_neg = p1_neg_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			nmag_q <= sum_mag;
			nneg_q <= sum_neg;
			dmag_q <= MAG_WIDTH'(pd_mag_q);
			dneg_q <= pd_neg_q;
		end
	end

	assign stat.gcd_fin = (nmag_q == '0) || (gb_q == '0) || (ga_q == gb_q);
	assign g_next       = (nmag_q == '0) ? MAG_WIDTH'(1) : (ga_q << k_q);
	assign g_diff       = {1'b0, ga_q} - {1'b0, gb_q};

	always_ff @(posedge clk) begin
		if (cmd.gcd_init) begin
			ga_q <= nmag_q;
			gb_q <= dmag_q;
			k_q  <= '0;
		end else if (cmd.gcd_step) begin
			if (stat.gcd_fin) begin
				g_q <= g_next;
			end else if (!ga_q[0] && !gb_q[0]) begin
				ga_q <= ga_q >> 1;
				gb_q <= gb_q >> 1;
				k_q  <= k_q + 1'b1;
			end else if (!ga_q[0]) begin
				ga_q <= ga_q >> 1;
			end else if (!gb_q[0]) begin
				gb_q <= gb_q >> 1;
			end else if (g_diff[MAG_WIDTH]) begin
				gb_q <= gb_q - ga_q;
			end else begin
				ga_q <= g_diff[MAG_WIDTH-1:0];
			end
		end
	end

	always_comb begin
		g_ext   = {1'b0, g_q};
		shn     = {rem_n_q, quo_n_q[MAG_WIDTH-1]};
		shd     = {rem_d_q, quo_d_q[MAG_WIDTH-1]};
		trial_n = shn - g_ext;
		trial_d = shd - g_ext;
	end

	always_ff @(posedge clk) begin
		if (cmd.gcd_step && stat.gcd_fin) begin
			rem_n_q <= '0;
			rem_d_q <= '0;
			quo_n_q <= nmag_q;
			quo_d_q <= dmag_q;
		end else if (cmd.div_step) begin
			if (shn >= g_ext) begin
				rem_n_q <= trial_n[MAG_WIDTH-1:0];
				quo_n_q <= {quo_n_q[MAG_WIDTH-2:0], 1'b1};
			end else begin
				rem_n_q <= shn[MAG_WIDTH-1:0];
				quo_n_q <= {quo_n_q[MAG_WIDTH-2:0], 1'b0};
			end
			if (shd >= g_ext) begin
				rem_d_q <= trial_d[MAG_WIDTH-1:0];
				quo_d_q <= {quo_d_q[MAG_WIDTH-2:0], 1'b1};
			end else begin
				rem_d_q <= shd[MAG_WIDTH-1:0];
				quo_d_q <= {quo_d_q[MAG_WIDTH-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		n_ext = EXT_WIDTH'(quo_n_q);
		d_ext = EXT_WIDTH'(quo_d_q);
		n_sgn = nneg_q ? (~n_ext + 1'b1) : n_ext;
		d_sgn = dneg_q ? (~d_ext + 1'b1) : d_ext;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			num_out_q <= n_sgn[NUM_OUT_WIDTH-1:0];
			den_out_q <= d_sgn[DEN_OUT_WIDTH-1:0];
		end
	end

	assign num_out = num_out_q;
	assign den_out = den_out_q;

	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gcd_step && !stat.gcd_fin |-> ga_q != '0)
		else $error("GCD operand collapsed to zero before reduction finished.");

	a_g_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gcd_step && stat.gcd_fin |=> g_q != '0)
		else $error("Reduction divisor is zero.");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_n_q < g_q) && (rem_d_q < g_q))
		else $error("Divider remainder is not below the divisor.");

endmodule

[sv/rau_ctrl.sv]
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer for the rational arithmetic unit: steps the datapath through
// multiplication, summation, GCD search and division, and owns the
// handshakes on both channels.
// ----------------------------------------------------------------------------
module rau_ctrl import rau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output rau_cmd_t  cmd,
	input  rau_stat_t stat
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_SUM,
		S_GINIT,
		S_GCD,
		S_DIV,
		S_OUT
	} state_t;

	state_t                 state_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   out_valid_q;
	logic                   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = MSEL_P1;
		case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_MUL1: cmd.mul_en = 1'b1;
			S_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_P2;
			end
			S_MUL3: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_DEN;
			end
			S_SUM:   cmd.sum = 1'b1;
			S_GINIT: cmd.gcd_init = 1'b1;
			S_GCD:   cmd.gcd_step = 1'b1;
			S_DIV:   cmd.div_step = 1'b1;
			S_OUT:   cmd.out_load = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_MUL3;
				S_MUL3:  state_q <= S_SUM;
				S_SUM:   state_q <= S_GINIT;
				S_GINIT: state_q <= S_GCD;
				S_GCD: begin
					if (stat.gcd_fin) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == COUNT_WIDTH'(MAG_WIDTH - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("Result register overwritten while a word was still waiting.");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_MUL1)
		else $error("Accepted word did not start the multiply sequence.");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q && state_q == S_IDLE)
		else $error("Loaded result was not presented.");

endmodule

[sv/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// The time from acceptance to result varies with the binary GCD search.
// One word is processed at a time; the GCD loop and the 33-step divider set
// the rate. A finished result waits in its output register while the next
// word is taken. Reset clears the sequencer and the result valid flag only.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	rau_in_if.sink    operand,
	rau_out_if.source result
);

	rau_cmd_t  cmd;
	rau_stat_t stat;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operand.valid),
		.in_ready  (operand.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	rau_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.opcode  (operand.opcode),
		.num_a   (operand.num_a),
		.den_a   (operand.den_a),
		.num_b   (operand.num_b),
		.den_b   (operand.den_b),
		.num_out (result.num_out),
		.den_out (result.den_out)
	);

endmodule

[dv/rau_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rau_result_checker
// Watches the operand and result channels of the rational arithmetic unit.
// Each accepted operand word is turned into the reduced fraction it should
// give, and each result word is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module rau_result_checker import rau_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	rau_in_if    operand,
	rau_out_if   result,
	output int   failures,
	output int   outstanding
);

	typedef struct {
		logic signed [NUM_OUT_WIDTH-1:0] num;
		logic signed [DEN_OUT_WIDTH-1:0] den;
	} fraction_t;

	fraction_t pending_fractions[$];

	initial begin
		failures    = 0;
		outstanding = 0;
	end

	// Products are formed exactly in 64 bits, then both parts are divided by
	// the GCD of their magnitudes, or by one when the numerator is zero.
	function automatic fraction_t reduced_fraction(opcode_t op, longint na, longint da,
			longint nb, longint db);
		longint    n;
		longint    d;
		longint    g;
		longint    a;
		longint    b;
		longint    t;
		fraction_t r;
		case (op)
			OP_ADD: begin
				n = nb * da + na * db;
				d = da * db;
			end
			OP_SUB: begin
				n = na * db - nb * da;
				d = da * db;
			end
			OP_MUL: begin
				n = na * nb;
				d = da * db;
			end
			default: begin
				n = na * db;
				d = da * nb;
			end
		endcase
		if (n == 0) begin
			g = 1;
		end else begin
			a = (n < 0) ? -n : n;
			b = (d < 0) ? -d : d;
			while (b != 0) begin
				t = a % b;
				a = b;
				b = t;
			end
			g = a;
		end
		r.num = NUM_OUT_WIDTH'(n / g);
		r.den = DEN_OUT_WIDTH'(d / g);
		return r;
	endfunction

	always @(posedge clk) begin
		fraction_t want;
		if (arst_n) begin
			if (operand.valid && operand.ready) begin
				pending_fractions.push_back(reduced_fraction(opcode_t'(operand.opcode),
					longint'(operand.num_a), longint'(operand.den_a),
					longint'(operand.num_b), longint'(operand.den_b)));
			end
			if (result.valid && result.ready) begin
				if (pending_fractions.size() == 0) begin
					$error("Result word with nothing expected: num_out=%0d den_out=%0d",
						result.num_out, result.den_out);
					failures++;
				end else begin
					want = pending_fractions.pop_front();
					if (result.num_out !== want.num) begin
						$error("num_out: expected %0d, got %0d", want.num, result.num_out);
						failures++;
					end
					if (result.den_out !== want.den) begin
						$error("den_out: expected %0d, got %0d", want.den, result.den_out);
						failures++;
					end
				end
			end
			outstanding = pending_fractions.size();
		end
	end

endmodule

[dv/tb_rational_arithmetic_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit
// Drives directed and random fraction words into the rational arithmetic
// unit with random gaps and stalls on both channels, including one long
// hold-off on the result side, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;

	import rau_pkg::*;

	localparam int STALL_LIMIT     = 5000;
	localparam int HOLD_OFF_CYCLES = 1000;
	localparam int HOLD_OFF_AT     = 30;
	localparam int RANDOM_WORDS    = 400;
	localparam int DRAIN_CYCLES    = 250;

	typedef logic signed [OPERAND_WIDTH-1:0] operand_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   failures;
	int   outstanding;
	int   idle_cycles = 0;
	int   results_taken = 0;

	rau_in_if  operand_ch ();
	rau_out_if result_ch ();

	rational_arithmetic_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (operand_ch),
		.result  (result_ch)
	);

	rau_result_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.operand     (operand_ch),
		.result      (result_ch),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	function automatic operand_t random_operand();
		operand_t v;
		case ($urandom_range(0, 7))
			0, 1: v = operand_t'($urandom_range(0, 16)) - operand_t'(8);
			2: begin
				case ($urandom_range(0, 4))
					0: v = -16'sd32768;
					1: v = 16'sd32767;
					2: v = -16'sd1;
					3: v = 16'sd1;
					default: v = 16'sd0;
				endcase
			end
			3: v = operand_t'($urandom_range(0, 512)) * operand_t'($urandom_range(1, 60));
			default: v = operand_t'($urandom);
		endcase
		return v;
	endfunction

	task automatic offer_word(opcode_t op, operand_t na, operand_t da, operand_t nb,
			operand_t db, bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			operand_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operand_ch.valid  <= 1'b1;
		operand_ch.opcode <= op;
		operand_ch.num_a  <= na;
		operand_ch.den_a  <= da;
		operand_ch.num_b  <= nb;
		operand_ch.den_b  <= db;
		do @(posedge clk); while (!operand_ch.ready);
	endtask

	initial begin
		opcode_t op;
		operand_ch.valid  = 1'b0;
		operand_ch.opcode = OP_ADD;
		operand_ch.num_a  = '0;
		operand_ch.den_a  = '0;
		operand_ch.num_b  = '0;
		operand_ch.den_b  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_word(OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b0);
		offer_word(OP_SUB, 16'sd1, -16'sd2, 16'sd1, -16'sd3, 1'b0);
		offer_word(OP_ADD, 16'sd0, 16'sd5, 16'sd0, 16'sd7, 1'b0);
		offer_word(OP_MUL, 16'sd3, 16'sd0, 16'sd4, 16'sd0, 1'b0);
		offer_word(OP_DIV, 16'sd5, 16'sd3, 16'sd0, 16'sd7, 1'b0);
		offer_word(OP_DIV, -16'sd5, 16'sd3, 16'sd0, 16'sd7, 1'b0);
		offer_word(OP_MUL, 16'sd0, 16'sd0, 16'sd7, 16'sd0, 1'b0);
		offer_word(OP_SUB, 16'sd6, 16'sd4, 16'sd6, 16'sd4, 1'b0);
		for (int k = 0; k < 4; k++) begin
			op = opcode_t'(k);
			offer_word(op, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
			offer_word(op, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
			offer_word(op, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 1'b0);
		end

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			op = opcode_t'($urandom_range(0, 3));
			offer_word(op, random_operand(), random_operand(), random_operand(),
				random_operand(), (i / 40) % 3 == 2);
		end
		operand_ch.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Result side: random stalls, runs without stalls, and one long hold-off
	// that lets the block fill up and refuse further operand words.
	initial begin
		int gap;
		result_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (results_taken == HOLD_OFF_AT)
				gap = HOLD_OFF_CYCLES;
			else if ((results_taken / 50) % 3 == 1)
				gap = 0;
			else
				gap = $urandom_range(0, 9);
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			results_taken++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((operand_ch.valid && operand_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

endmodule

[filelist.f]
sv/rau_pkg.sv
sv/rau_in_if.sv
sv/rau_out_if.sv
sv/rau_datapath.sv
sv/rau_ctrl.sv
sv/rational_arithmetic_unit.sv
dv/rau_result_checker.sv
dv/tb_rational_arithmetic_unit.sv
